>>> hw/rtl/spse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spse_pkg: shared types and constants of the scale peak estimator
// Field widths, register map, reset values and the transaction structs
// that pass between the front, the command queue and the back end.
// ----------------------------------------------------------------------------
package spse_pkg;

   localparam int RESP_W = 32;   // Laplacian response
   localparam int SIG_W  = 16;   // Q8.8 sigma values
   localparam int IDX_W  = 6;    // scale index on the result

   localparam int MAX_SCALES_DEF = 16;
   localparam int CMD_DEPTH_DEF  = 2;

   // register map, byte address = 4 * index
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_SIGMA_BASE    = 2'd0;
   localparam logic [1:0] REG_SIGMA_STEP    = 2'd1;
   localparam logic [1:0] REG_DEFAULT_SCALE = 2'd2;

   localparam logic [SIG_W-1:0] SIGMA_BASE_RST    = 16'd256;
   localparam logic [SIG_W-1:0] SIGMA_STEP_RST    = 16'd362;
   localparam logic [SIG_W-1:0] DEFAULT_SCALE_RST = 16'd256;

   typedef struct packed {
      logic signed [RESP_W-1:0] response;
      logic                     last_scale;
   } req_type;

   typedef struct packed {
      logic [SIG_W-1:0] scale_estimate;
      logic             peak_found;
      logic [IDX_W-1:0] peak_index;
   } rsp_type;

   typedef struct packed {
      logic [SIG_W-1:0] sigma_base;
      logic [SIG_W-1:0] sigma_step;
      logic [SIG_W-1:0] default_scale;
   } cfg_type;

   // one finished pixel: the peak triple, or just the no-peak flag
   typedef struct packed {
      logic                     found;
      logic [IDX_W-1:0]         idx;
      logic signed [RESP_W-1:0] left;
      logic signed [RESP_W-1:0] center;
      logic signed [RESP_W-1:0] right;
   } cmd_type;

endpackage
`default_nettype wire

>>> hw/rtl/spse_cmd_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spse_cmd_fifo: short pixel command queue
// Register-based queue between the front and the back end.
// ----------------------------------------------------------------------------
module spse_cmd_fifo #(
   parameter int DEPTH = spse_pkg::CMD_DEPTH_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   wr_en,
   input  spse_pkg::cmd_type     wr_data,
   output logic                  full,
   input  wire                   rd_en,
   output spse_pkg::cmd_type     rd_data,
   output logic                  empty
);
   import spse_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/spse_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spse_front: response tracker and peak detector
// Keeps the last two responses of the current pixel, flags the first
// interior peak and emits one command per pixel on its last scale.
// ----------------------------------------------------------------------------
module spse_front #(
   parameter int MAX_SCALES = spse_pkg::MAX_SCALES_DEF
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 accept,
   input  spse_pkg::req_type   req_data,
   output logic                cmd_push,
   output spse_pkg::cmd_type   cmd_data
);
   import spse_pkg::*;

   localparam int CW = $clog2(MAX_SCALES);

   logic signed [RESP_W-1:0] older_ff, older_in;
   logic signed [RESP_W-1:0] newer_ff, newer_in;
   logic signed [RESP_W-1:0] hl_ff, hl_in, hc_ff, hc_in, hr_ff, hr_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            hidx_ff, hidx_in;
   logic                     peak_ff, peak_in;
   logic                     sat_ff, sat_in;
   logic [CW:0]              count_inc;
   logic signed [RESP_W-1:0] v;
   logic                     peak_now;

   assign v         = req_data.response;
   assign count_inc = {1'b0, count_ff} + (CW+1)'(1);
   assign peak_now  = !sat_ff && !peak_ff && (count_ff >= CW'(2)) &&
                      (newer_ff >= older_ff) && (newer_ff >= v);

   always_comb begin
      older_in = older_ff;
      newer_in = newer_ff;
      hl_in    = hl_ff;
      hc_in    = hc_ff;
      hr_in    = hr_ff;
      count_in = count_ff;
      hidx_in  = hidx_ff;
      peak_in  = peak_ff;
      sat_in   = sat_ff;
      if (accept) begin
         if (!sat_ff) begin
            if (peak_now) begin
               peak_in = 1'b1;
               hl_in   = older_ff;
               hc_in   = newer_ff;
               hr_in   = v;
               hidx_in = count_ff - CW'(1);
            end
            older_in = newer_ff;
            newer_in = v;
            if (count_inc >= (CW+1)'(MAX_SCALES)) begin
               sat_in = 1'b1;
            end else begin
               count_in = count_inc[CW-1:0];
            end
         end
         // pixel done: clear for the next one
         if (req_data.last_scale) begin
            older_in = '0;
            newer_in = '0;
            count_in = '0;
            hidx_in  = '0;
            peak_in  = 1'b0;
            sat_in   = 1'b0;
         end
      end
   end

   always_comb begin
      cmd_push        = accept && req_data.last_scale;
      cmd_data.found  = peak_ff || peak_now;
      cmd_data.idx    = peak_now ? IDX_W'(count_ff - CW'(1)) : IDX_W'(hidx_ff);
      cmd_data.left   = peak_now ? older_ff : hl_ff;
      cmd_data.center = peak_now ? newer_ff : hc_ff;
      cmd_data.right  = peak_now ? v : hr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         older_ff <= '0;
         newer_ff <= '0;
         count_ff <= '0;
         hidx_ff  <= '0;
         peak_ff  <= 1'b0;
         sat_ff   <= 1'b0;
      end else begin
         older_ff <= older_in;
         newer_ff <= newer_in;
         count_ff <= count_in;
         hidx_ff  <= hidx_in;
         peak_ff  <= peak_in;
         sat_ff   <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      hl_ff <= hl_in;
      hc_ff <= hc_in;
      hr_ff <= hr_in;
   end

   a_sat_count : assert property (@(posedge clock) disable iff (reset)
      sat_ff |-> count_ff == CW'(MAX_SCALES - 1))
      else $error("saturated pixel with unexpected scale count");

   a_peak_interior : assert property (@(posedge clock) disable iff (reset)
      peak_ff |-> hidx_ff != '0)
      else $error("held peak at scale zero");

endmodule
`default_nettype wire

>>> hw/rtl/spse_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spse_back: centroid interpolation engine
// Takes one pixel command, works out the shifted centroid offset with a
// bit-serial divider and saturates the sigma (default scale if no peak),
// and holds it in the result register until it is popped.
// ----------------------------------------------------------------------------
module spse_back (
   input  wire                 clock,
   input  wire                 reset,
   input  spse_pkg::cfg_type   cfg,
   input  wire                 cmd_avail,
   input  spse_pkg::cmd_type   cmd_data,
   output logic                cmd_pop,
   output logic                empty,
   input  wire                 pop,
   output spse_pkg::rsp_type   rsp_data
);
   import spse_pkg::*;

   localparam int MAG_W  = 48;
   localparam int SUM_W  = 35;
   localparam int CNT_W  = $clog2(MAG_W);
   localparam int BASE_W = 23;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SUM   = 7'b0000010,
      ST_MUL   = 7'b0000100,
      ST_ABS   = 7'b0001000,
      ST_DIV   = 7'b0010000,
      ST_FIN   = 7'b0100000,
      ST_WRITE = 7'b1000000
   } state_type;

   state_type                state_ff, state_in;
   cmd_type                  cmd_ff;
   logic signed [RESP_W:0]   diff_ff;
   logic signed [RESP_W+1:0] lcr_ff;
   logic [RESP_W:0]          norm_ff;
   logic [BASE_W-1:0]        basep_ff;
   logic signed [MAG_W:0]    prod_ff;
   logic [SUM_W-1:0]         sum_ff;
   logic [MAG_W-1:0]         mag_ff;
   logic [SUM_W-1:0]         rem_ff;
   logic                     neg_ff;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   rsp_type                  res_ff;
   logic                     valid_ff, valid_in;
   rsp_type                  out_ff;

   logic [RESP_W-1:0]        tl, tc, tr;
   logic signed [MAG_W+1:0]  prod_full;
   logic signed [SUM_W:0]    sum_full;
   logic signed [MAG_W:0]    prod_neg;
   logic [SUM_W:0]           rem_sh;
   logic                     qbit;
   logic [SUM_W:0]           rem_sub;
   logic signed [MAG_W:0]    off;
   logic signed [MAG_W+1:0]  sig;
   logic                     load;

   // magnitude of a non-positive response, zero otherwise
   always_comb begin
      tl = (cmd_ff.left   <= 0) ? RESP_W'(-cmd_ff.left)   : '0;
      tc = (cmd_ff.center <= 0) ? RESP_W'(-cmd_ff.center) : '0;
      tr = (cmd_ff.right  <= 0) ? RESP_W'(-cmd_ff.right)  : '0;
   end

   always_comb begin
      prod_full = diff_ff * $signed({1'b0, cfg.sigma_step});
      sum_full  = (SUM_W+1)'(lcr_ff) + $signed({3'b000, norm_ff})
                + $signed({2'b00, norm_ff, 1'b0});
      prod_neg  = -prod_ff;
      rem_sh    = {rem_ff, mag_ff[MAG_W-1]};
      qbit      = (rem_sh >= {1'b0, sum_ff});
      rem_sub   = qbit ? rem_sh - {1'b0, sum_ff} : rem_sh;
      off       = neg_ff ? -$signed({1'b0, mag_ff}) : $signed({1'b0, mag_ff});
      sig       = (MAG_W+2)'(off) + $signed({(MAG_W+2-BASE_W)'(0), basep_ff});
   end

   assign cmd_pop  = (state_ff == ST_IDLE) && cmd_avail;
   assign load     = (state_ff == ST_WRITE) && (!valid_ff || pop);
   assign empty    = !valid_ff;
   assign rsp_data = out_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_avail) begin
               state_in = cmd_data.found ? ST_SUM : ST_WRITE;
            end
         end
         ST_SUM:   state_in = ST_MUL;
         ST_MUL:   state_in = ST_ABS;
         ST_ABS: begin
            state_in = ST_DIV;
            cnt_in   = '0;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(MAG_W - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN:   state_in = ST_WRITE;
         ST_WRITE: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (pop && valid_ff) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            cmd_ff                <= cmd_data;
            res_ff.scale_estimate <= cfg.default_scale;
            res_ff.peak_found     <= 1'b0;
            res_ff.peak_index     <= '0;
         end
         ST_SUM: begin
            diff_ff  <= (RESP_W+1)'(cmd_ff.right) - (RESP_W+1)'(cmd_ff.left);
            lcr_ff   <= (RESP_W+2)'(cmd_ff.left) + (RESP_W+2)'(cmd_ff.center)
                      + (RESP_W+2)'(cmd_ff.right);
            norm_ff  <= (RESP_W+1)'(1) + (RESP_W+1)'(tl) + (RESP_W+1)'(tc)
                      + (RESP_W+1)'(tr);
            basep_ff <= BASE_W'(cfg.sigma_base) + BASE_W'(cmd_ff.idx * cfg.sigma_step);
         end
         ST_MUL: begin
            prod_ff <= prod_full[MAG_W:0];
            sum_ff  <= sum_full[SUM_W-1:0];
         end
         ST_ABS: begin
            neg_ff <= prod_ff[MAG_W];
            mag_ff <= prod_ff[MAG_W] ? prod_neg[MAG_W-1:0] : prod_ff[MAG_W-1:0];
            rem_ff <= '0;
         end
         ST_DIV: begin
            // one quotient bit per cycle, shifted into the dividend register
            rem_ff <= rem_sub[SUM_W-1:0];
            mag_ff <= {mag_ff[MAG_W-2:0], qbit};
         end
         ST_FIN: begin
            res_ff.peak_found <= 1'b1;
            res_ff.peak_index <= cmd_ff.idx;
            if (sig < 0) begin
               res_ff.scale_estimate <= '0;
            end else if (sig > (MAG_W+2)'(65535)) begin
               res_ff.scale_estimate <= '1;
            end else begin
               res_ff.scale_estimate <= sig[SIG_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= res_ff;
      end
   end

   a_div_nonzero : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> sum_ff != '0)
      else $error("centroid divisor is zero");

   a_no_peak_index : assert property (@(posedge clock) disable iff (reset)
      load && !res_ff.peak_found |-> res_ff.peak_index == '0)
      else $error("no-peak result carries a scale index");

endmodule
`default_nettype wire

>>> hw/rtl/scale_peak_subsample_estimator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scale_peak_subsample_estimator: scale-space peak finder with centroid
// sub-scale interpolation
// Streams one pixel's Laplacian responses, finds the first interior peak
// and reports its interpolated sigma in Q8.8, or the default scale.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  --------  ---------  -------------------  ------------------------------
//  request   in         push / full          req_data  (response, last_scale)
//  result    out        empty / pop          rsp_data  (estimate, found, index)
//  csr       in/out     psel/penable/pready  paddr, pwdata, prdata
//
//  The front takes one response per cycle, without gaps, while the queue
//  has room; a pixel's command enters the queue on its last_scale item.
//  The back end sends a pixel without a peak from idle straight to write;
//  one with a peak passes sum, mul, abs, the one-bit-per-cycle divider, fin.
//  Up to CMD_DEPTH pixels wait in the queue, one result in the output reg.
//  Synchronous active-high reset; no clearing pass, ready the cycle after.
//  full rises only when the queue is full; a stalled pop never stalls push
//  until the front has filled the queue behind it.
//
module scale_peak_subsample_estimator #(
   parameter int MAX_SCALES = spse_pkg::MAX_SCALES_DEF,
   parameter int CMD_DEPTH  = spse_pkg::CMD_DEPTH_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // request channel
   input  wire                                  push,
   output logic                                 full,
   input  spse_pkg::req_type                    req_data,
   // result channel
   output logic                                 empty,
   input  wire                                  pop,
   output spse_pkg::rsp_type                    rsp_data,
   // register port
   input  wire                                  psel,
   input  wire                                  penable,
   input  wire                                  pwrite,
   input  wire  [spse_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire  [spse_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [spse_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);
   import spse_pkg::*;

   logic [SIG_W-1:0] base_ff, base_in;
   logic [SIG_W-1:0] step_ff, step_in;
   logic [SIG_W-1:0] dflt_ff, dflt_in;
   logic [1:0]       reg_idx;
   logic             csr_wr;
   cfg_type          cfg;

   logic             accept;
   logic             cmd_push;
   cmd_type          cmd_wr;
   cmd_type          cmd_rd;
   logic             q_full, q_empty, cmd_pop;

   // register port: no wait states
   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_comb begin
      base_in = base_ff;
      step_in = step_ff;
      dflt_in = dflt_ff;
      if (csr_wr) begin
         case (reg_idx)
            REG_SIGMA_BASE:    base_in = pwdata[SIG_W-1:0];
            REG_SIGMA_STEP:    step_in = pwdata[SIG_W-1:0];
            REG_DEFAULT_SCALE: dflt_in = pwdata[SIG_W-1:0];
            default: begin
               // drop writes past the register map
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_SIGMA_BASE:    prdata = CSR_DATA_W'(base_ff);
         REG_SIGMA_STEP:    prdata = CSR_DATA_W'(step_ff);
         REG_DEFAULT_SCALE: prdata = CSR_DATA_W'(dflt_ff);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= SIGMA_BASE_RST;
         step_ff <= SIGMA_STEP_RST;
         dflt_ff <= DEFAULT_SCALE_RST;
      end else begin
         base_ff <= base_in;
         step_ff <= step_in;
         dflt_ff <= dflt_in;
      end
   end

   assign cfg.sigma_base    = base_ff;
   assign cfg.sigma_step    = step_ff;
   assign cfg.default_scale = dflt_ff;

   // hold off the request side only while the command queue is full
   assign full   = q_full;
   assign accept = push && !q_full;

   spse_front #(
      .MAX_SCALES (MAX_SCALES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .cmd_push (cmd_push),
      .cmd_data (cmd_wr)
   );

   spse_cmd_fifo #(
      .DEPTH (CMD_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_push),
      .wr_data (cmd_wr),
      .full    (q_full),
      .rd_en   (cmd_pop),
      .rd_data (cmd_rd),
      .empty   (q_empty)
   );

   spse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_avail (!q_empty),
      .cmd_data  (cmd_rd),
      .cmd_pop   (cmd_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
